// File: rtl/segment_collinear_node_search_defines.svh
// assertion macros shared by the collinear node search rtl
`ifndef SEGMENT_COLLINEAR_NODE_SEARCH_DEFINES_SVH
`define SEGMENT_COLLINEAR_NODE_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define SCNS_ASSERT_IMPLY(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);
`define SCNS_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define SCNS_ASSERT_IMPLY(lbl, clk, rstn, cond, prop, msg)
`define SCNS_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)
`endif
`endif

// File: rtl/scns_pkg.sv
// shared types and constants of the collinear node search
package scns_pkg;

    localparam int COORD_W         = 48;
    localparam int CFG_W           = 37;
    localparam int DIST_W          = 49;
    localparam int ERR_W           = 49;
    localparam int SLOPE_FRAC      = 62;
    localparam int SLOPE_W         = 63;
    localparam int COORD_FRAC_BITS = 36;
    localparam int S_TDATA_W       = 240;
    localparam int M_TDATA_W       = 144;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = 2;
    localparam int QCNT_W          = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 37'd6872;

    typedef enum logic [1:0] {
        REG_INTERVAL_MARGIN = 2'd0,
        REG_LINE_TOLERANCE  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                      is_node;
        logic                      last;
        logic                      major_is_x;
        logic [DIST_W-1:0]         minor_dist;
        logic signed [COORD_W-1:0] x_a;
        logic signed [COORD_W-1:0] y_a;
        logic signed [COORD_W-1:0] x_b;
        logic signed [COORD_W-1:0] y_b;
        logic signed [COORD_W-1:0] z;
    } item_t;

endpackage

// File: rtl/scns_front.sv
// front: unpacks a beat, picks the major axis and minor span of a segment
module scns_front import scns_pkg::*; (
    input  logic [S_TDATA_W-1:0] tdata,
    input  logic                 tuser,
    input  logic                 tlast,
    output item_t                item
);

    logic signed [DIST_W-1:0] xdiff, ydiff;
    logic [DIST_W-1:0]        xdist, ydist;
    logic                     mx;

    always_comb begin
        item.is_node = tuser;
        item.last    = tlast;
        item.x_a     = tdata[47:0];
        item.y_a     = tdata[95:48];
        item.x_b     = tdata[143:96];
        item.y_b     = tdata[191:144];
        item.z       = tdata[239:192];
        xdiff = DIST_W'(item.x_a) - DIST_W'(item.x_b);
        ydiff = DIST_W'(item.y_a) - DIST_W'(item.y_b);
        xdist = xdiff[DIST_W-1] ? DIST_W'(-xdiff) : DIST_W'(xdiff);
        ydist = ydiff[DIST_W-1] ? DIST_W'(-ydiff) : DIST_W'(ydiff);
        // equal spans make y the major axis
        mx = xdist > ydist;
        item.major_is_x = mx;
        item.minor_dist = mx ? ydist : xdist;
    end

endmodule

// File: rtl/scns_queue.sv
// short item queue between front and back
`include "segment_collinear_node_search_defines.svh"
module scns_queue import scns_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_req,
    output item_t pop_item
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push, pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_req && pop_valid;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_item;
    end

    `SCNS_ASSERT_NEXT(a_q_grow, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")
    `SCNS_ASSERT_NEXT(a_q_shrink, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - 1'b1, "queue count lost a pop")

endmodule

// File: rtl/scns_div.sv
// bit-serial restoring divider, floor(num * 2^62 / den), num <= den
module scns_div import scns_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [COORD_W-1:0]  num,
    input  logic [COORD_W-1:0]  den,
    output logic [SLOPE_W-1:0]  q,
    output logic                done
);

    logic                busy_reg, done_reg;
    logic [5:0]          cnt_reg;
    logic [COORD_W-1:0]  r_reg, den_reg;
    logic [SLOPE_W-1:0]  q_reg;
    logic [COORD_W:0]    trial, diff;
    logic                ge;

    always_comb begin
        // first step compares the numerator itself, later ones shift first
        trial = (cnt_reg == '0) ? {1'b0, r_reg} : {r_reg, 1'b0};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                r_reg    <= num;
                den_reg  <= den;
                q_reg    <= '0;
            end else if (busy_reg) begin
                r_reg   <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
                q_reg   <= {q_reg[SLOPE_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'(SLOPE_FRAC)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign q    = q_reg;
    assign done = done_reg;

endmodule

// File: rtl/scns_mul.sv
// slope times coordinate over four 32x32 partial products, truncated to q.36
module scns_mul import scns_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [SLOPE_W-1:0]        a,
    input  logic [COORD_W-1:0]        b,
    input  logic                      neg,
    output logic signed [COORD_W:0]   p,
    output logic                      done
);

    logic                     busy_reg, done_reg, neg_reg;
    logic [2:0]               cnt_reg;
    logic [SLOPE_W-1:0]       a_reg;
    logic [COORD_W-1:0]       b_reg;
    logic [63:0]              prod_reg;
    logic [1:0]               pshift_reg;
    logic [110:0]             acc_reg, addend;
    logic signed [COORD_W:0]  p_reg;
    logic [31:0]              ai, bj;
    logic [COORD_W-1:0]       mag;

    always_comb begin
        ai     = cnt_reg[1] ? {1'b0, a_reg[62:32]} : a_reg[31:0];
        bj     = cnt_reg[0] ? {16'b0, b_reg[47:32]} : b_reg[31:0];
        addend = {47'b0, prod_reg} << {pshift_reg, 5'b0};
        mag    = acc_reg[109:62];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
                neg_reg  <= neg;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg < 3'd4) begin
                    prod_reg   <= ai * bj;
                    pshift_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                end
                if (cnt_reg != 3'd0 && cnt_reg <= 3'd4) acc_reg <= acc_reg + addend;
                if (cnt_reg == 3'd5) begin
                    p_reg    <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign p    = p_reg;
    assign done = done_reg;

endmodule

// File: rtl/scns_back.sv
// back: line setup for segments, node test and best-node tracking, result register
`include "segment_collinear_node_search_defines.svh"
module scns_back import scns_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [M_TDATA_W-1:0] m_data,
    output logic                 m_found
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEG_ORDER, ST_SEG_DIV, ST_SEG_MUL,
        ST_NODE_CHK, ST_NODE_MUL, ST_NODE_ERR, ST_NODE_UPD, ST_EMIT
    } state_t;

    localparam logic [ERR_W-1:0] ONE_Q = ERR_W'(1) << COORD_FRAC_BITS;

    state_t                     state_reg;
    item_t                      cur_reg;
    logic [CFG_W-1:0]           margin_reg, tol_reg;
    logic                       major_is_x_reg, any_found_reg, slope_neg_reg, den_zero_reg;
    logic signed [COORD_W-1:0]  span_low_reg, span_high_reg, hi_min_reg;
    logic signed [COORD_W-1:0]  node_maj_reg, node_mnr_reg;
    logic signed [COORD_W-1:0]  best_x_reg, best_y_reg, best_z_reg;
    logic [SLOPE_W-1:0]         slope_mag_reg;
    logic signed [COORD_W+1:0]  intercept_reg;
    logic signed [COORD_W+2:0]  line_reg;
    logic signed [COORD_W+3:0]  diff_reg;
    logic [ERR_W-1:0]           best_error_reg;
    logic                       mul_start_reg, m_valid_reg, m_found_reg;
    logic [M_TDATA_W-1:0]       m_data_reg;

    logic signed [COORD_W-1:0]  maj0, min0, maj1, min1, lo_maj, lo_min, hi_maj, hi_min;
    logic signed [COORD_W:0]    den_diff, min_diff;
    logic [COORD_W:0]           min_abs;
    logic [COORD_W-1:0]         den_c, num_c;
    logic signed [COORD_W-1:0]  n_maj, n_mnr, mul_v;
    logic signed [COORD_W+1:0]  win_lo, win_hi;
    logic                       in_window;
    logic [COORD_W+3:0]         err;
    logic                       div_done, mul_done, div_start;
    logic [SLOPE_W-1:0]         div_q;
    logic signed [COORD_W:0]    mul_p;
    logic [COORD_W-1:0]         mul_b;

    // segment ordering along the major axis
    always_comb begin
        maj0 = cur_reg.major_is_x ? cur_reg.x_a : cur_reg.y_a;
        min0 = cur_reg.major_is_x ? cur_reg.y_a : cur_reg.x_a;
        maj1 = cur_reg.major_is_x ? cur_reg.x_b : cur_reg.y_b;
        min1 = cur_reg.major_is_x ? cur_reg.y_b : cur_reg.x_b;
        if (maj0 < maj1) begin
            lo_maj = maj0; lo_min = min0; hi_maj = maj1; hi_min = min1;
        end else begin
            lo_maj = maj1; lo_min = min1; hi_maj = maj0; hi_min = min0;
        end
        den_diff = (COORD_W+1)'(hi_maj) - (COORD_W+1)'(lo_maj);
        min_diff = (COORD_W+1)'(hi_min) - (COORD_W+1)'(lo_min);
        min_abs  = min_diff[COORD_W] ? (COORD_W+1)'(-min_diff) : (COORD_W+1)'(min_diff);
        den_c    = den_diff[COORD_W-1:0];
        num_c    = min_abs[COORD_W-1:0];
    end

    // node window test, error magnitude and multiplier operand select
    always_comb begin
        n_maj     = major_is_x_reg ? cur_reg.x_a : cur_reg.y_a;
        n_mnr     = major_is_x_reg ? cur_reg.y_a : cur_reg.x_a;
        win_lo    = (COORD_W+2)'(span_low_reg) + $signed({13'b0, margin_reg});
        win_hi    = (COORD_W+2)'(span_high_reg) - $signed({13'b0, margin_reg});
        in_window = ((COORD_W+2)'(n_maj) > win_lo) && ((COORD_W+2)'(n_maj) < win_hi);
        err       = diff_reg[COORD_W+3] ? (COORD_W+4)'(-diff_reg) : (COORD_W+4)'(diff_reg);
        mul_v     = (state_reg == ST_SEG_MUL) ? span_high_reg : node_maj_reg;
        mul_b     = mul_v[COORD_W-1] ? COORD_W'(-mul_v) : COORD_W'(mul_v);
    end

    assign div_start = state_reg == ST_SEG_ORDER;
    assign q_pop     = state_reg == ST_IDLE;

    scns_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_c),
        .den     (den_c),
        .q       (div_q),
        .done    (div_done)
    );

    scns_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (slope_mag_reg),
        .b       (mul_b),
        .neg     (slope_neg_reg ^ mul_v[COORD_W-1]),
        .p       (mul_p),
        .done    (mul_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= CFG_RESET;
            tol_reg    <= CFG_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_INTERVAL_MARGIN) margin_reg <= cfg_wdata;
            if (cfg_addr == REG_LINE_TOLERANCE)  tol_reg    <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            major_is_x_reg <= 1'b0;
            span_low_reg   <= '0;
            span_high_reg  <= '0;
            slope_mag_reg  <= '0;
            slope_neg_reg  <= 1'b0;
            intercept_reg  <= '0;
            best_error_reg <= '0;
            any_found_reg  <= 1'b0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_z_reg     <= '0;
            mul_start_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cur_reg   <= q_item;
                        state_reg <= q_item.is_node ? ST_NODE_CHK : ST_SEG_ORDER;
                    end
                end
                ST_SEG_ORDER: begin
                    major_is_x_reg <= cur_reg.major_is_x;
                    span_low_reg   <= lo_maj;
                    span_high_reg  <= hi_maj;
                    hi_min_reg     <= hi_min;
                    slope_neg_reg  <= hi_min < lo_min;
                    den_zero_reg   <= den_c == '0;
                    best_error_reg <= cur_reg.minor_dist + ONE_Q;
                    any_found_reg  <= 1'b0;
                    best_x_reg     <= '0;
                    best_y_reg     <= '0;
                    best_z_reg     <= '0;
                    state_reg      <= ST_SEG_DIV;
                end
                ST_SEG_DIV: begin
                    if (div_done) begin
                        // zero-length segment keeps a flat line
                        slope_mag_reg <= den_zero_reg ? '0 : div_q;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_SEG_MUL;
                    end
                end
                ST_SEG_MUL: begin
                    if (mul_done) begin
                        intercept_reg <= (COORD_W+2)'(hi_min_reg) - (COORD_W+2)'(mul_p);
                        state_reg     <= cur_reg.last ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_NODE_CHK: begin
                    node_maj_reg <= n_maj;
                    node_mnr_reg <= n_mnr;
                    if (in_window) begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_NODE_MUL;
                    end else begin
                        state_reg <= cur_reg.last ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_NODE_MUL: begin
                    if (mul_done) begin
                        line_reg  <= (COORD_W+3)'(mul_p) + (COORD_W+3)'(intercept_reg);
                        state_reg <= ST_NODE_ERR;
                    end
                end
                ST_NODE_ERR: begin
                    diff_reg  <= (COORD_W+4)'(node_mnr_reg) - (COORD_W+4)'(line_reg);
                    state_reg <= ST_NODE_UPD;
                end
                ST_NODE_UPD: begin
                    if (err < {15'b0, tol_reg}) begin
                        any_found_reg <= 1'b1;
                        if (err < {3'b0, best_error_reg}) begin
                            best_error_reg <= err[ERR_W-1:0];
                            best_x_reg     <= cur_reg.x_a;
                            best_y_reg     <= cur_reg.y_a;
                            best_z_reg     <= cur_reg.z;
                        end
                    end
                    state_reg <= cur_reg.last ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (!m_valid_reg) begin
                        m_valid_reg    <= 1'b1;
                        m_found_reg    <= any_found_reg;
                        m_data_reg     <= {best_z_reg, best_y_reg, best_x_reg};
                        any_found_reg  <= 1'b0;
                        best_x_reg     <= '0;
                        best_y_reg     <= '0;
                        best_z_reg     <= '0;
                        best_error_reg <= '1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_found = m_found_reg;

    `SCNS_ASSERT_IMPLY(a_div_owner, aclk, aresetn, div_done, state_reg == ST_SEG_DIV, "divider finished outside segment setup")
    `SCNS_ASSERT_IMPLY(a_mul_owner, aclk, aresetn, mul_done, state_reg == ST_SEG_MUL || state_reg == ST_NODE_MUL, "multiplier finished with no owner")
    `SCNS_ASSERT_NEXT(a_emit_clears, aclk, aresetn, state_reg == ST_EMIT && !m_valid_reg, m_valid_reg && !any_found_reg && state_reg == ST_IDLE, "emit did not load result and clear search")

endmodule

// File: rtl/segment_collinear_node_search.sv
// top level of the collinear node search
//
//  port group   dir  beat contents
//  s_axis_*     in   tdata: x_first, y_first, x_second, y_second, height; tuser: mode; tlast
//  m_axis_*     out  tdata: node_x, node_y, node_z; tuser: found
//  cfg_*        in   write of interval_margin (index 0) or line_tolerance (index 1)
//
// a segment beat runs through the back end's one-bit-a-cycle slope divider (63 steps)
// and then the 4-product slope multiplier
// a node beat in the window runs the multiplier too, one outside skips it; last beats emit
// the queue takes up to 4 beats, so input flows on until it is full while the back end works
// aresetn is synchronous; a result waits in the output register while m_axis_tready is low
module segment_collinear_node_search import scns_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // x_first, y_first, x_second, y_second, height
    input  logic                 s_axis_tuser,  // mode
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // node_x, node_y, node_z
    output logic                 m_axis_tuser,  // found
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    item_t front_item, head_item;
    logic  head_valid, head_pop;

    scns_front u_front (
        .tdata (s_axis_tdata),
        .tuser (s_axis_tuser),
        .tlast (s_axis_tlast),
        .item  (front_item)
    );

    scns_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_item  (front_item),
        .pop_valid  (head_valid),
        .pop_req    (head_pop),
        .pop_item   (head_item)
    );

    scns_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (head_valid),
        .q_item    (head_item),
        .q_pop     (head_pop),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_found   (m_axis_tuser)
    );

endmodule
